FILE: hw/rtl/modexp_pkg.sv
// Shared constants and controller/datapath interface types for the
// modular exponentiation block. No dependencies.
`default_nettype none

package modexp_pkg;

  // Number of exponent bits scanned by default
  localparam int EXP_BITS_DEF = 63;

  // Modulus and its multiples used by the reducer
  localparam logic [29:0] PRIME      = 30'd1000000007;
  localparam logic [31:0] PRIME_W32  = 32'd1000000007;
  localparam logic [31:0] PRIME2_W32 = 32'd2000000014;

  // Reciprocal of the modulus, floor(2^60 / P), fits in 31 bits
  localparam logic [63:0] BARRETT_FULL = (64'd1 << 60) / 64'd1000000007;
  localparam logic [30:0] BARRETT_M    = BARRETT_FULL[30:0];

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture a new base and exponent
    logic issue_sq;   // start running_base * running_base
    logic issue_mul;  // start accumulator * running_base, step exponent
    logic emit;       // move the accumulator into the output register
  } modexp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic exp_zero;   // no set bits left in the exponent
    logic out_free;   // output register can take a word this cycle
  } modexp_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/modexp_dp.sv
// Datapath: operand registers, four-stage Barrett modular multiplier and
// the output register. Depends on modexp_pkg.
`default_nettype none

module modexp_dp
  import modexp_pkg::*;
#(
  parameter int ExpBits = EXP_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [29:0]           base_value_i,
  input  wire logic [62:0]           exponent_i,
  input  wire modexp_cmd_t           cmd_i,
  output modexp_status_t             status_o,
  input  wire logic                  out_stall_i,
  output logic                       out_valid_o,
  output logic [29:0]                power_result_o
);

  typedef enum logic {
    DST_BASE = 1'b0,
    DST_ACC  = 1'b1
  } dst_e;

  logic [29:0]        acc_q;
  logic [29:0]        base_q;
  logic [ExpBits-1:0] rem_q;
  logic [29:0]        base_red;

  // Multiplier pipeline
  logic [29:0] op_a;
  logic        v0;
  dst_e        dst0;
  logic [59:0] prod_d, prod_q;
  logic [61:0] t_d, t_q;
  logic [31:0] plo_q;
  logic [30:0] quot;
  logic [31:0] qp_lo;
  logic [31:0] r_d, r_q;
  logic [31:0] r_m1, r_m2;
  logic [29:0] fin;
  logic        v1_q, v2_q, v3_q;
  dst_e        dst1_q, dst2_q, dst3_q;

  logic        out_valid_q;
  logic [29:0] result_q;

  assign base_red = (base_value_i >= PRIME) ? base_value_i - PRIME : base_value_i;

  // Squares and multiplies share one pipe; a multiply only writes back
  // when the current exponent bit is set.
  assign op_a = cmd_i.issue_sq ? base_q : acc_q;
  assign v0   = cmd_i.issue_sq | (cmd_i.issue_mul & rem_q[0]);
  assign dst0 = cmd_i.issue_sq ? DST_BASE : DST_ACC;

  assign prod_d = {30'd0, op_a} * {30'd0, base_q};
  assign t_d    = {31'd0, prod_q[59:29]} * {31'd0, BARRETT_M};
  assign quot   = t_q[61:31];
  assign qp_lo  = 32'(quot) * PRIME_W32;
  assign r_d    = plo_q - qp_lo;
  assign r_m1   = r_q - PRIME_W32;
  assign r_m2   = r_q - PRIME2_W32;

  // Barrett estimate leaves at most two extra multiples of the modulus
  always_comb begin
    if (r_q >= PRIME2_W32) begin
      fin = r_m2[29:0];
    end else if (r_q >= PRIME_W32) begin
      fin = r_m1[29:0];
    end else begin
      fin = r_q[29:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q <= v0;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    dst1_q <= dst0;
    t_q    <= t_d;
    plo_q  <= prod_q[31:0];
    dst2_q <= dst1_q;
    r_q    <= r_d;
    dst3_q <= dst2_q;

    if (cmd_i.load) begin
      acc_q  <= 30'd1;
      base_q <= base_red;
      rem_q  <= exponent_i[ExpBits-1:0];
    end else begin
      if (v3_q) begin
        if (dst3_q == DST_ACC) begin
          acc_q <= fin;
        end else begin
          base_q <= fin;
        end
      end
      if (cmd_i.issue_mul) begin
        rem_q <= rem_q >> 1;
      end
    end

    if (cmd_i.emit) begin
      result_q <= acc_q;
    end
  end

  assign status_o.exp_zero = (rem_q == '0);
  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign power_result_o    = result_q;

endmodule

`default_nettype wire

FILE: hw/rtl/modexp_ctrl.sv
// Controller state machine: sequences loads, square and multiply issues
// and the output handoff. Depends on modexp_pkg.
`default_nettype none

module modexp_ctrl
  import modexp_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  output modexp_cmd_t          cmd_o,
  input  wire modexp_status_t  status_i
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SQ    = 7'b0000010,
    ST_MUL   = 7'b0000100,
    ST_WAIT1 = 7'b0001000,
    ST_WAIT2 = 7'b0010000,
    ST_FLUSH = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd_o.issue_sq = 1'b1;
        state_d        = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.issue_mul = 1'b1;
        state_d         = ST_WAIT1;
      end
      ST_WAIT1: begin
        state_d = ST_WAIT2;
      end
      ST_WAIT2: begin
        // new square reads the base written back at the end of this cycle
        state_d = status_i.exp_zero ? ST_FLUSH : ST_SQ;
      end
      ST_FLUSH: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

FILE: hw/rtl/modular_exponentiation.sv
// Modular exponentiation modulo 1000000007, right-to-left square and multiply.
// The controller runs one square-and-multiply round per exponent bit, through the
// highest set bit (one round for a zero exponent). A new input word is taken
// only once the previous result has been emitted; each exponent bit waits
// for a square through the four-stage modular multiplier. Reset is async,
// active low: controller idle, output empty, no clearing pass.
`default_nettype none

module modular_exponentiation
  import modexp_pkg::*;
#(
  // Low exponent bits that count; higher bits are ignored
  parameter int ExpBits = EXP_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input channel: base residue and exponent
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [29:0] base_value_i,
  input  wire logic [62:0] exponent_i,
  // Output channel: base^exponent mod P
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [29:0]      power_result_o
);

  // The controller only issues commands; all arithmetic and the output
  // register live in the datapath. Per exponent bit the controller issues a
  // square, then a multiply that writes back only if the bit is set, then
  // waits for the squared base before the next bit.
  modexp_cmd_t    cmd;
  modexp_status_t status;

  modexp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  // The output register parts the two channels: a finished word waits there
  // while the next input word is already accepted and worked on.
  modexp_dp #(
    .ExpBits (ExpBits)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .base_value_i   (base_value_i),
    .exponent_i     (exponent_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .power_result_o (power_result_o)
  );

`ifndef NO_ASSERTIONS
  // Once a word is taken, hold off the input until the result is handed over
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while a word is in flight");

  // Never overwrite a result word that is still waiting downstream
  a_emit_into_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> status.out_free)
    else $error("result emitted into a full output register");

  // A new output word only appears right after the controller emits one
  a_out_from_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.emit))
    else $error("output valid rose without an emit");
`endif

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for modular_exponentiation (base^exponent mod 1000000007).
// Depends on modexp_pkg and the modular_exponentiation RTL; needs no files at run time.

module tb;
  import modexp_pkg::*;

  // Modulus and exponent mask, kept local so the predictor stands on its own
  localparam logic [63:0] MODULUS   = 64'd1000000007;
  localparam int          EXP_WIDTH = EXP_BITS_DEF;
  localparam logic [62:0] EXP_MASK  = 63'((64'd1 << EXP_WIDTH) - 64'd1);
  localparam logic [62:0] EXP_ONES  = {63{1'b1}};
  localparam logic [29:0] BASE_ONES = {30{1'b1}};

  // Idle cycles with no word moving on either side before the run is abandoned.
  // Covers the long receiver hold-off, the widest sender gap and a full 63-bit job.
  localparam int IDLE_LIMIT  = 10000;
  // Long receiver hold-off, started once enough results have arrived
  localparam int HOLD_CYCLES = 3000;
  localparam int HOLD_AFTER  = 200;
  // Drain time after the last expected word: one worst-case job and some margin
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    logic [29:0] base;
    logic [62:0] exponent;
  } exp_word_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [29:0] base_value = '0;
  logic [62:0] exponent = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [29:0] power_result;

  exp_word_t   pending_words[$];
  logic [29:0] power_expect[$];
  int          fail_count = 0;
  int          results_seen = 0;

  modular_exponentiation uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .base_value_i   (base_value),
    .exponent_i     (exponent),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .power_result_o (power_result)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Right-to-left square and multiply on 64-bit products; 30-bit operands never
  // overflow. Reduce the base first, since a 30-bit base can exceed the modulus.
  function automatic logic [29:0] mod_power(logic [29:0] b, logic [62:0] e);
    logic [63:0] acc;
    logic [63:0] sq;
    logic [62:0] rem;
    acc = 64'd1;
    sq  = {34'd0, b} % MODULUS;
    rem = e & EXP_MASK;
    while (rem != '0) begin
      if (rem[0]) begin
        acc = (acc * sq) % MODULUS;
      end
      rem = rem >> 1;
      sq  = (sq * sq) % MODULUS;
    end
    return acc[29:0];
  endfunction

  function automatic void add_word(logic [29:0] b, logic [62:0] e);
    exp_word_t w;
    w.base     = b;
    w.exponent = e;
    pending_words = {pending_words, w};
  endfunction

  // Random 63-bit pattern, cut down to a random bit length with its top bit set,
  // so job lengths spread over every latency the block can have.
  function automatic logic [62:0] rand_exponent();
    logic [63:0] raw;
    int          len;
    raw = {$urandom, $urandom};
    len = $urandom_range(0, 63);
    if (len == 0) begin
      return '0;
    end
    raw = raw & ((64'd1 << len) - 64'd1);
    raw[len-1] = 1'b1;
    return raw[62:0];
  endfunction

  function automatic logic [29:0] rand_base();
    int pick;
    pick = $urandom_range(0, 15);
    case (pick)
      0: begin
        return 30'($urandom_range(0, 3));
      end
      1: begin
        // Unreduced residue, at or above the modulus
        return 30'($urandom_range(1000000007, 30'h3FFF_FFFF));
      end
      2: begin
        return 30'($urandom);
      end
      3: begin
        return 30'(1000000007 - $urandom_range(1, 4));
      end
      default: begin
        return 30'($urandom_range(0, 1000000006));
      end
    endcase
  endfunction

  // Sender gap lengths: often none, sometimes short, now and then long enough
  // to land on any phase of a running job.
  function automatic int rand_gap();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      return 0;
    end else if (pick < 8) begin
      return $urandom_range(1, 8);
    end
    return $urandom_range(10, 300);
  endfunction

  // Driver: offer the head of pending_words; hold valid and payload while
  // stalled, and only start a gap after a word has been taken.
  int gap_left;
  int burst_left;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      base_value <= '0;
      exponent   <= '0;
      gap_left   = 0;
      burst_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        power_expect = {power_expect, mod_power(base_value, exponent)};
        void'(pending_words.pop_front());
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          in_valid   <= 1'b1;
          base_value <= pending_words[0].base;
          exponent   <= pending_words[0].exponent;
          // Once the burst count runs out, close the burst on this word and schedule the gap that follows it
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = rand_gap();
          end else begin
            burst_left = burst_left - 1;
          end
        end
      end
    end
  end

  // Receiver: stall on segments of random mode and length, plus one long
  // hold-off that lets the block fill up and push back on its input.
  stall_mode_e stall_mode;
  int          seg_left;
  int          hold_left;
  bit          hold_done;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_mode = STALL_NONE;
      seg_left   = 0;
      hold_left  = 0;
      hold_done  = 1'b0;
    end else begin
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left   = $urandom_range(20, 400);
          stall_mode = stall_mode_e'($urandom_range(0, 3));
        end else begin
          seg_left = seg_left - 1;
        end
        case (stall_mode)
          STALL_NONE: begin
            out_stall <= 1'b0;
          end
          STALL_LIGHT: begin
            out_stall <= ($urandom_range(0, 3) == 0);
          end
          STALL_HEAVY: begin
            out_stall <= ($urandom_range(0, 7) != 0);
          end
          default: begin
            out_stall <= ~out_stall;
          end
        endcase
      end
    end
  end

  // Monitor: match each delivered word against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (power_expect.size() == 0) begin
        $error("power_result: no word expected, actual %0d", power_result);
        fail_count = fail_count + 1;
      end else begin
        logic [29:0] want;
        want = power_expect.pop_front();
        if (power_result !== want) begin
          $error("power_result mismatch: expected %0d, actual %0d", want, power_result);
          fail_count = fail_count + 1;
        end
      end
      results_seen <= results_seen + 1;
    end
  end

  // Watchdog: abandon the run when no word moves on either side for too long
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    // Directed words: zero exponent (also with zero base), zero base, unreduced
    // bases, field extremes and an exponent with a single high bit.
    add_word(30'd0, 63'd0);
    add_word(30'd5, 63'd0);
    add_word(30'd0, 63'd1);
    add_word(30'd0, EXP_ONES);
    add_word(30'd1, EXP_ONES);
    add_word(30'd2, 63'd1);
    add_word(30'd1000000006, 63'd1);
    add_word(30'd1000000006, 63'd2);
    add_word(30'd1000000006, EXP_ONES);
    add_word(30'd1000000007, 63'd5);
    add_word(30'd1000000008, EXP_ONES);
    add_word(BASE_ONES, 63'd0);
    add_word(BASE_ONES, 63'd1);
    add_word(BASE_ONES, EXP_ONES);
    add_word(30'd2, 63'h4000_0000_0000_0000);
    add_word(30'd3, 63'h5555_5555_5555_5555);
    add_word(30'd7, 63'h2AAA_AAAA_AAAA_AAAA);
    add_word(30'd1000000005, EXP_ONES);
    add_word(30'd123456789, 63'd1000000006);
    add_word(30'h2AAA_AAAA, 63'h0000_0000_FFFF_FFFF);
    add_word(30'h1555_5555, 63'h7FFF_FFFF_0000_0000);
    // Random words
    repeat (1030) begin
      add_word(rand_base(), rand_exponent());
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every word to go in and every result to come back, then drain
    while (pending_words.size() != 0 || power_expect.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/modexp_pkg.sv
hw/rtl/modexp_dp.sv
hw/rtl/modexp_ctrl.sv
hw/rtl/modular_exponentiation.sv
tb/tb.sv
